FILE: sv/sssa_pkg.sv
// Shared types, constants and the arctangent table of the steer angle solver.
`timescale 1ns / 1ps
package sssa_pkg;

  localparam int unsigned NumMods = 4;
  localparam int unsigned TabLen  = 24;
  localparam int unsigned VecW    = 34;  // Q2.30 module vectors plus growth
  localparam int unsigned AngW    = 26;  // fine angle, 2^-24 turn, with headroom

  localparam logic signed [VecW-1:0] CordicGain = 34'sd652032874;
  localparam logic signed [AngW-1:0] HalfFine    = 26'sd8388608;
  localparam logic signed [AngW-1:0] QuarterFine = 26'sd4194304;
  localparam logic [17:0]            QuarterTurn = 18'd16384;
  localparam logic [15:0]            HalfTurn    = 16'd32768;

  localparam logic [2:0] RegDirBase = 3'd0;

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StRot   = 5'b00010,
    StMul   = 5'b00100,
    StVec   = 5'b01000,
    StOut   = 5'b10000
  } state_e;

  // Control bundle from the sequencer to the chain.
  typedef struct packed {
    logic load_rot;  // seed rotation mode
    logic load_vec;  // seed vectoring mode
    logic step;      // advance one CORDIC step
    logic vec_mode;  // 1: vectoring, 0: rotation
  } chain_ctl_t;

  function automatic logic signed [AngW-1:0] atan_fine(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    unique case (i)
      5'd0:  r = 26'sd2097152;
      5'd1:  r = 26'sd1238021;
      5'd2:  r = 26'sd654136;
      5'd3:  r = 26'sd332050;
      5'd4:  r = 26'sd166669;
      5'd5:  r = 26'sd83416;
      5'd6:  r = 26'sd41718;
      5'd7:  r = 26'sd20860;
      5'd8:  r = 26'sd10430;
      5'd9:  r = 26'sd5215;
      5'd10: r = 26'sd2608;
      5'd11: r = 26'sd1304;
      5'd12: r = 26'sd652;
      5'd13: r = 26'sd326;
      5'd14: r = 26'sd163;
      5'd15: r = 26'sd81;
      5'd16: r = 26'sd41;
      5'd17: r = 26'sd20;
      5'd18: r = 26'sd10;
      5'd19: r = 26'sd5;
      5'd20: r = 26'sd3;
      5'd21: r = 26'sd1;
      5'd22: r = 26'sd1;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/sssa_cell.sv
// One CORDIC cell: holds one module's vector and angle, steps in place.
`timescale 1ns / 1ps
module sssa_cell import sssa_pkg::*; (
  input  logic                   clk_i,
  input  chain_ctl_t             ctl_i,
  input  logic [4:0]             iter_i,
  input  logic signed [VecW-1:0] seed_x_i,
  input  logic signed [VecW-1:0] seed_y_i,
  input  logic signed [AngW-1:0] seed_z_i,
  output logic signed [VecW-1:0] x_o,
  output logic signed [VecW-1:0] y_o,
  output logic signed [AngW-1:0] z_o
);

  logic signed [VecW-1:0] x_q, x_d, y_q, y_d;
  logic signed [AngW-1:0] z_q, z_d;
  logic signed [VecW-1:0] dx, dy;
  logic                   pos;

  assign dx  = y_q >>> iter_i;
  assign dy  = x_q >>> iter_i;
  // rotation drives z to zero, vectoring drives y to zero
  assign pos = ctl_i.vec_mode ? !y_q[VecW-1] : !z_q[AngW-1];

  always_comb begin
    x_d = x_q;
    y_d = y_q;
    z_d = z_q;
    if (ctl_i.load_rot || ctl_i.load_vec) begin
      x_d = seed_x_i;
      y_d = seed_y_i;
      z_d = seed_z_i;
    end else if (ctl_i.step) begin
      if (ctl_i.vec_mode == pos) begin
        // vectoring with y >= 0: clockwise, add angle; rotation with z < 0: same signs
        x_d = x_q + dx;
        y_d = y_q - dy;
      end else begin
        x_d = x_q - dx;
        y_d = y_q + dy;
      end
      if (pos) begin
        z_d = ctl_i.vec_mode ? z_q + atan_fine(iter_i) : z_q - atan_fine(iter_i);
      end else begin
        z_d = ctl_i.vec_mode ? z_q - atan_fine(iter_i) : z_q + atan_fine(iter_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign x_o = x_q;
  assign y_o = y_q;
  assign z_o = z_q;

endmodule

FILE: sv/swerve_steer_angle_solver.sv
// Swerve steer angle solver: four CORDIC cells plus sequencer and rate multiplier.
//
// Each command makes two full CORDIC passes (sin/cos then heading) through the
// row of four cells, which run all modules side by side. Between the passes one
// shared multiplier scales the eight cosine and sine values by the rotation rate,
// one per cycle, and the heading pass is seeded once the last product has landed.
// A new command is taken once the previous result has been moved into the output
// register.
`timescale 1ns / 1ps
module swerve_steer_angle_solver import sssa_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] joy_x_i,
  input  logic signed [15:0] joy_y_i,
  input  logic signed [15:0] turn_rate_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [17:0]        angle_front_left_o,
  output logic [17:0]        angle_front_right_o,
  output logic [17:0]        angle_back_left_o,
  output logic [17:0]        angle_back_right_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam logic [4:0] LastIter = 5'(CORDIC_STEPS - 1);
  localparam logic [3:0] MulLast  = 4'(2 * NumMods);

  state_e     state_q, state_d;
  logic [4:0] iter_q, iter_d;
  logic [3:0] mcnt_q, mcnt_d;
  chain_ctl_t ctl;

  logic [15:0] dir_q [NumMods];
  logic [15:0] off_q [NumMods];
  logic [15:0] head_q [NumMods];
  logic        neg_q [NumMods];
  logic signed [15:0] jx_q, jy_q, rate_q;
  logic signed [VecW-1:0] vx_q [NumMods];
  logic signed [VecW-1:0] vy_q [NumMods];

  logic signed [VecW-1:0] seed_x [NumMods];
  logic signed [VecW-1:0] seed_y [NumMods];
  logic signed [AngW-1:0] seed_z [NumMods];
  logic signed [VecW-1:0] cx [NumMods];
  logic signed [VecW-1:0] cy [NumMods];
  logic signed [AngW-1:0] cz [NumMods];

  logic        ovalid_q;
  logic [17:0] ang_q [NumMods];

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumMods; m++) begin
        dir_q[m] <= '0;
        off_q[m] <= '0;
      end
    end else if (cfg_valid_i) begin
      for (int m = 0; m < NumMods; m++) begin
        if (cfg_index_i == RegDirBase + 3'(m)) dir_q[m] <= cfg_data_i;
        if (cfg_index_i == 3'(m + NumMods)) off_q[m] <= cfg_data_i;
      end
    end
  end

  wire accept = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != StIdle);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    mcnt_d  = mcnt_q;
    ctl     = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ctl.load_rot = 1'b1;
          iter_d  = '0;
          state_d = StRot;
        end
      end
      StRot: begin
        ctl.step = 1'b1;
        iter_d = iter_q + 5'd1;
        if (iter_q == LastIter) begin
          mcnt_d  = '0;
          state_d = StMul;
        end
      end
      StMul: begin
        // seed the heading pass once the last product has landed
        if (mcnt_q == MulLast) begin
          ctl.load_vec = 1'b1;
          ctl.vec_mode = 1'b1;
          iter_d  = '0;
          state_d = StVec;
        end else begin
          mcnt_d = mcnt_q + 4'd1;
        end
      end
      StVec: begin
        ctl.step     = 1'b1;
        ctl.vec_mode = 1'b1;
        iter_d = iter_q + 5'd1;
        if (iter_q == LastIter) state_d = StOut;
      end
      StOut: begin
        if (!ovalid_q || !out_stall_i) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      iter_q  <= '0;
      mcnt_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
      mcnt_q  <= mcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      jx_q   <= joy_x_i;
      jy_q   <= joy_y_i;
      rate_q <= turn_rate_i;
    end
  end

  // cell seeds: in idle, fold direction into [-1/4, 1/4] turn; else seed heading with x >= 0
  always_comb begin
    for (int m = 0; m < NumMods; m++) begin
      logic signed [AngW-1:0] z0;
      z0 = AngW'($signed({dir_q[m], 8'd0}));
      if (state_q == StIdle) begin
        seed_x[m] = CordicGain;
        seed_y[m] = '0;
        if (z0 > QuarterFine)       seed_z[m] = z0 - HalfFine;
        else if (z0 < -QuarterFine) seed_z[m] = z0 + HalfFine;
        else                        seed_z[m] = z0;
      end else begin
        if (vx_q[m][VecW-1]) begin
          seed_x[m] = -vx_q[m];
          seed_y[m] = -vy_q[m];
          seed_z[m] = HalfFine;
        end else begin
          seed_x[m] = vx_q[m];
          seed_y[m] = vy_q[m];
          seed_z[m] = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle) begin
      for (int m = 0; m < NumMods; m++) begin
        logic signed [AngW-1:0] z0;
        z0 = AngW'($signed({dir_q[m], 8'd0}));
        neg_q[m] <= (z0 > QuarterFine) || (z0 < -QuarterFine);
      end
    end
  end

  for (genvar g = 0; g < NumMods; g++) begin : g_cell
    sssa_cell u_cell (
      .clk_i    (clk_i),
      .ctl_i    (ctl),
      .iter_i   (iter_q),
      .seed_x_i (seed_x[g]),
      .seed_y_i (seed_y[g]),
      .seed_z_i (seed_z[g]),
      .x_o      (cx[g]),
      .y_o      (cy[g]),
      .z_o      (cz[g])
    );
  end

  // shared multiplier: one cos or sin per cycle
  logic [1:0]             msel;
  logic signed [VecW-1:0] mop;
  logic signed [49:0]     prod;
  logic signed [VecW-1:0] term;
  assign msel = mcnt_q[2:1];
  always_comb begin
    mop = mcnt_q[0] ? cy[msel] : cx[msel];
    if (neg_q[msel]) mop = -mop;
  end
  assign prod = 50'(mop) * 50'(rate_q);
  assign term = VecW'(prod >>> 15);

  always_ff @(posedge clk_i) begin
    if (state_q == StMul && mcnt_q != MulLast) begin
      if (mcnt_q[0]) vy_q[msel] <= VecW'($signed({jy_q, 15'd0})) + term;
      else           vx_q[msel] <= VecW'($signed({jx_q, 15'd0})) + term;
    end
  end

  // heading round-off and special cases
  logic [15:0] new_head [NumMods];
  always_comb begin
    for (int m = 0; m < NumMods; m++) begin
      logic [23:0] zw;
      zw = cz[m][23:0];
      if (vy_q[m] == '0) begin
        if (vx_q[m] == '0)          new_head[m] = head_q[m];
        else if (vx_q[m][VecW-1])   new_head[m] = HalfTurn;
        else                        new_head[m] = '0;
      end else begin
        new_head[m] = 16'((25'(zw) + 25'd128) >> 8);
      end
    end
  end

  wire take = (state_q == StOut) && (!ovalid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int m = 0; m < NumMods; m++) head_q[m] <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (take) begin
        for (int m = 0; m < NumMods; m++) head_q[m] <= new_head[m];
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      for (int m = 0; m < NumMods; m++) begin
        ang_q[m] <= 18'(new_head[m]) + 18'(off_q[m]) + QuarterTurn;
      end
    end
  end

  assign out_valid_o         = ovalid_q;
  assign angle_front_left_o  = ang_q[0];
  assign angle_front_right_o = ang_q[1];
  assign angle_back_left_o   = ang_q[2];
  assign angle_back_right_o  = ang_q[3];

endmodule
